>>> hdl/word_count_search_tree_assert.svh
// Assertion macros for the word count search tree block.
// Included by wcst_walk, which checks its own logic; needs clk_i and rst_ni in scope.
`ifndef WORD_COUNT_SEARCH_TREE_ASSERT_SVH
`define WORD_COUNT_SEARCH_TREE_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define WCST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define WCST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WCST_ASSERT_SAME(lbl, ante, cons, msg)
`define WCST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/wcst_pkg.sv
// Shared types and constants of the word count search tree block.
// No dependencies; imported by every module of the block except wcst_ram.
`timescale 1ns / 1ps

package wcst_pkg;

  localparam int NODES       = 256;
  localparam int COUNT_W     = 16;
  localparam int IDX_W       = $clog2(NODES);
  localparam int NODE_CNT_W  = $clog2(NODES + 1);
  localparam int HEAD_W      = 16;
  localparam int TAIL_W      = 64;
  localparam int RES_COUNT_W = 16;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [NODE_CNT_W-1:0] node_cnt_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef struct packed {
    logic [HEAD_W-1:0] word_head;
    logic [TAIL_W-1:0] word_tail;
  } word_t;

  typedef struct packed {
    logic [RES_COUNT_W-1:0] word_count;
    logic                   newly_added;
    logic                   table_full;
  } result_t;

  typedef struct packed {
    logic [HEAD_W-1:0] key_head;
    logic [TAIL_W-1:0] key_tail;
    count_t            count;
    idx_t              left;
    idx_t              right;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    node_t wdata;
    logic  re;
    idx_t  raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LINK
  } state_e;

  localparam count_t COUNT_MAX = {COUNT_W{1'b1}};
  localparam count_t COUNT_ONE = count_t'(1);

endpackage

>>> hdl/wcst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module wcst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hdl/wcst_walk.sv
// Tree walk controller: compares the word against one node per cycle, then
// updates a count, links a new node or flags a full table. Depends on wcst_pkg and the assert header.
`timescale 1ns / 1ps
`include "word_count_search_tree_assert.svh"

module wcst_walk (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  wcst_pkg::word_t   word_i,
  output logic              done_o,
  output wcst_pkg::result_t result_o,
  output wcst_pkg::mem_req_t mem_o,
  input  wcst_pkg::node_t   rdata_i
);

  import wcst_pkg::*;

  state_e    state_q, state_d;
  word_t     word_q, word_d;
  idx_t      cur_q, cur_d;
  idx_t      new_idx_q, new_idx_d;
  logic      go_left_q, go_left_d;
  node_cnt_t node_cnt_q, node_cnt_d;
  result_t   res_q, res_d;
  logic      done_q, done_d;

  logic      accept;
  logic      tree_empty;
  logic      key_eq;
  logic      key_lt;
  idx_t      next_idx;
  logic      no_child;
  logic      pool_full;
  count_t    count_inc;

  assign accept     = start && (state_q == ST_IDLE);
  assign tree_empty = (node_cnt_q == '0);
  assign key_eq     = ({word_q.word_head, word_q.word_tail} ==
                       {rdata_i.key_head, rdata_i.key_tail});
  assign key_lt     = ({word_q.word_head, word_q.word_tail} <
                       {rdata_i.key_head, rdata_i.key_tail});
  assign next_idx   = key_lt ? rdata_i.left : rdata_i.right;
  assign no_child   = (next_idx == '0) ||
                      (node_cnt_t'(next_idx) >= node_cnt_q);
  assign pool_full  = (node_cnt_q >= node_cnt_t'(NODES));
  assign count_inc  = (rdata_i.count == COUNT_MAX) ? COUNT_MAX : rdata_i.count + COUNT_ONE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !tree_empty) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (key_eq) begin
          state_d = ST_IDLE;
        end else if (no_child) begin
          state_d = pool_full ? ST_IDLE : ST_LINK;
        end
      end
      ST_LINK: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    word_d     = word_q;
    cur_d      = cur_q;
    new_idx_d  = new_idx_q;
    go_left_d  = go_left_q;
    node_cnt_d = node_cnt_q;
    res_d      = res_q;
    done_d     = 1'b0;
    mem_o      = '0;
    mem_o.wdata = rdata_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          word_d = word_i;
          cur_d  = '0;
          if (tree_empty) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = '0;
            mem_o.wdata = '{key_head: word_i.word_head, key_tail: word_i.word_tail,
                            count: COUNT_ONE, left: '0, right: '0};
            node_cnt_d  = node_cnt_t'(1);
            res_d       = '{word_count: RES_COUNT_W'(COUNT_ONE), newly_added: 1'b1,
                            table_full: 1'b0};
            done_d      = 1'b1;
          end else begin
            mem_o.re    = 1'b1;
            mem_o.raddr = '0;
          end
        end
      end
      ST_WALK: begin
        if (key_eq) begin
          mem_o.we          = 1'b1;
          mem_o.waddr       = cur_q;
          mem_o.wdata.count = count_inc;
          res_d  = '{word_count: RES_COUNT_W'(count_inc), newly_added: 1'b0,
                     table_full: 1'b0};
          done_d = 1'b1;
        end else if (no_child) begin
          if (pool_full) begin
            res_d = '{word_count: '0, newly_added: 1'b0, table_full: 1'b1};
          end else begin
            mem_o.we    = 1'b1;
            mem_o.waddr = node_cnt_q[IDX_W-1:0];
            mem_o.wdata = '{key_head: word_q.word_head, key_tail: word_q.word_tail,
                            count: COUNT_ONE, left: '0, right: '0};
            new_idx_d   = node_cnt_q[IDX_W-1:0];
            go_left_d   = key_lt;
            node_cnt_d  = node_cnt_q + node_cnt_t'(1);
            res_d       = '{word_count: RES_COUNT_W'(COUNT_ONE), newly_added: 1'b1,
                            table_full: 1'b0};
          end
          done_d = 1'b1;
        end else begin
          mem_o.re    = 1'b1;
          mem_o.raddr = next_idx;
          cur_d       = next_idx;
        end
      end
      ST_LINK: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = cur_q;
        if (go_left_q) begin
          mem_o.wdata.left = new_idx_q;
        end else begin
          mem_o.wdata.right = new_idx_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      node_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      node_cnt_q <= node_cnt_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    cur_q     <= cur_d;
    new_idx_q <= new_idx_d;
    go_left_q <= go_left_d;
    res_q     <= res_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `WCST_ASSERT_SAME(a_cnt_bound, 1'b1, node_cnt_q <= node_cnt_t'(NODES), "node count above pool size")
  `WCST_ASSERT_SAME(a_no_rw_clash, mem_o.we && mem_o.re, mem_o.waddr != mem_o.raddr, "read and write hit one entry")
  `WCST_ASSERT_SAME(a_flags_excl, done_q, !(res_q.newly_added && res_q.table_full), "new and full flags both set")
  `WCST_ASSERT_NEXT(a_grow_reports, node_cnt_d != node_cnt_q, done_q && res_q.newly_added, "node added without a new-word result")
  `WCST_ASSERT_SAME(a_done_has_cause, done_q, $past(busy) || $past(start), "result without a transaction")

endmodule

>>> hdl/word_count_search_tree.sv
// Top level of the word count search tree: walk controller plus node memory.
// Depends on wcst_pkg, wcst_walk and wcst_ram.
//
//   Channel   Handshake            Payload
//   word      start / busy         word_i   (word_head, word_tail)
//   result    done_o strobe        result_o (word_count, newly_added, table_full)
//
// On an empty tree the word is written as the root at once. Otherwise the root is read,
// nodes are visited until the word is found or dropped, and a new node is then linked.
// The walk is bounded by the single read port of the node memory: one node per cycle.
// The result is registered on result_o with done_o, high for one cycle, in the cycle after the decision.
// The receiver cannot stall, so a result never holds off the next transaction.
// Reset clears the state, the node count and done_o; node memory contents need no clearing.
`timescale 1ns / 1ps

module word_count_search_tree (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  wcst_pkg::word_t   word_i,
  output logic              done_o,
  output wcst_pkg::result_t result_o
);

  import wcst_pkg::*;

  mem_req_t mem_req;
  node_t    rdata;

  wcst_walk u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .word_i   (word_i),
    .done_o   (done_o),
    .result_o (result_o),
    .mem_o    (mem_req),
    .rdata_i  (rdata)
  );

  wcst_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for word_count_search_tree: directed table, repeated and random words.
// Depends on wcst_pkg and the word_count_search_tree RTL; predicts results with its own tree unless a probe pins them.
`timescale 1ns / 1ps

module tb_top;
  import wcst_pkg::*;

  localparam int WORD_W       = $bits(word_t);
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_GAP      = 16;
  localparam int PHASE_ITEMS  = 400;
  localparam int PHASES       = 4;
  localparam int PROBES       = 21;

  typedef logic [WORD_W-1:0] word_bits_t;

  typedef struct {
    word_bits_t  key;
    int unsigned reps;
    bit          pinned;
    result_t     want;
  } probe_t;

  localparam result_t RES_NONE      = '0;
  localparam result_t RES_NEW       = '{word_count: 16'd1, newly_added: 1'b1, table_full: 1'b0};
  localparam result_t RES_SECOND    = '{word_count: 16'd2, newly_added: 1'b0, table_full: 1'b0};

  logic    clk_i   = 1'b0;
  logic    rst_ni  = 1'b0;
  logic    start   = 1'b0;
  word_t   word_i  = '0;
  logic    busy;
  logic    done_o;
  result_t result_o;

  bit      pin_en  = 1'b0;
  result_t pin_res = '0;

  word_bits_t  tree_key   [NODES];
  count_t      tree_hits  [NODES];
  int unsigned tree_left  [NODES];
  int unsigned tree_right [NODES];
  int unsigned tree_size  = 0;

  result_t     tally_q [$];
  word_bits_t  seen_words [$];
  word_bits_t  last_fresh = '0;
  int unsigned idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  probe_t probes [PROBES] = '{
    '{80'h0000_0000000000000000, 1,     1'b1, RES_NEW},
    '{80'h0000_0000000000000000, 1,     1'b1, RES_SECOND},
    '{80'hFFFF_FFFFFFFFFFFFFFFF, 1,     1'b1, RES_NEW},
    '{80'hFFFF_FFFFFFFFFFFFFFFF, 1,     1'b1, RES_SECOND},
    '{80'h0000_FFFFFFFFFFFFFFFF, 1,     1'b1, RES_NEW},
    '{80'hFFFF_0000000000000000, 1,     1'b1, RES_NEW},
    '{80'h6865_6C6C6F0000000000, 1,     1'b1, RES_NEW},
    '{80'h6865_6C70000000000000, 1,     1'b0, RES_NONE},
    '{80'h6865_6C6C6F0000000000, 1,     1'b1, RES_SECOND},
    '{80'h6100_0000000000000000, 1,     1'b1, RES_NEW},
    '{80'h6100_0062000000000000, 1,     1'b1, RES_NEW},
    '{80'h6100_0000000000000001, 1,     1'b1, RES_NEW},
    '{80'h0000_0000000000000001, 1,     1'b1, RES_NEW},
    '{80'h8000_0000000000000000, 1,     1'b1, RES_NEW},
    '{80'h7FFF_FFFFFFFFFFFFFFFF, 1,     1'b1, RES_NEW},
    '{80'h6162_636465666768696A, 1,     1'b1, RES_NEW},
    '{80'h6162_636465666768696A, 1,     1'b1, RES_SECOND},
    '{80'h6100_0062000000000000, 1,     1'b1, RES_SECOND},
    '{80'h0000_0000000000000000, 40,    1'b0, RES_NONE},
    '{80'h0000_0000000000000000, 1,     1'b0, RES_NONE},
    '{80'hFFFF_FFFFFFFFFFFFFFFF, 1,     1'b0, RES_NONE}
  };

  int unsigned phase_idle [PHASES] = '{57, 0, 9, 57};

  word_count_search_tree i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .word_i   (word_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned add_node(word_bits_t key);
    int unsigned n;
    n = tree_size;
    tree_key[n]   = key;
    tree_hits[n]  = COUNT_ONE;
    tree_left[n]  = 0;
    tree_right[n] = 0;
    tree_size     = n + 1;
    return n;
  endfunction

  function automatic result_t count_word(word_bits_t key);
    result_t     r;
    int unsigned cur;
    int unsigned nxt;
    int unsigned n;
    bit          below;
    r   = '0;
    cur = 0;
    if (tree_size == 0) begin
      n = add_node(key);
      r.word_count  = 16'd1;
      r.newly_added = 1'b1;
      return r;
    end
    for (int unsigned steps = 0; steps < NODES; steps++) begin
      if (key == tree_key[cur]) begin
        if (tree_hits[cur] != COUNT_MAX) tree_hits[cur] = tree_hits[cur] + 1'b1;
        r.word_count = tree_hits[cur];
        return r;
      end
      below = key < tree_key[cur];
      nxt   = below ? tree_left[cur] : tree_right[cur];
      if (nxt == 0 || nxt >= tree_size) begin
        if (tree_size >= NODES) begin
          r.table_full = 1'b1;
        end else begin
          n = add_node(key);
          if (below) tree_left[cur] = n;
          else tree_right[cur] = n;
          r.word_count  = 16'd1;
          r.newly_added = 1'b1;
        end
        return r;
      end
      cur = nxt;
    end
    return r;
  endfunction

  function automatic word_bits_t fresh_word();
    word_bits_t  w;
    int unsigned pick;
    int unsigned len;
    int unsigned pos;
    pick = $urandom_range(99);
    w    = '0;
    if (pick < 40 || seen_words.size() == 0) begin
      len = $urandom_range(10);
      for (int unsigned k = 0; k < len; k++) begin
        w[WORD_W-1-8*k -: 8] = 8'h61 + 8'($urandom_range(7));
      end
    end else if (pick < 55) begin
      w = word_bits_t'({$urandom, $urandom, $urandom});
    end else if (pick < 70) begin
      w = last_fresh + 1'b1;
    end else if (pick < 85) begin
      w   = seen_words[$urandom_range(seen_words.size() - 1)];
      pos = $urandom_range(9);
      w[WORD_W-1-8*pos -: 8] = 8'($urandom);
    end else begin
      w   = seen_words[$urandom_range(seen_words.size() - 1)];
      len = $urandom_range(9);
      for (int unsigned k = len; k < 10; k++) w[WORD_W-1-8*k -: 8] = 8'h00;
    end
    return w;
  endfunction

  task automatic note_miss(input string what, input longint unsigned want_v,
                           input longint unsigned got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %0h, got %0h", what, want_v, got_v);
    end
  endtask

  task automatic send_word(input word_bits_t w, input bit pinned, input result_t want);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) begin
        word_i <= word_bits_t'({$urandom, $urandom, $urandom});
        @(posedge clk_i);
      end
    end
    word_i  <= w;
    pin_en  <= pinned;
    pin_res <= want;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  always @(posedge clk_i) begin : scoreboard
    result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (tally_q.size() == 0) begin
          note_miss("unexpected transaction", 0, result_o);
        end else begin
          want = tally_q.pop_front();
          if (result_o.word_count != want.word_count)
            note_miss("word_count", want.word_count, result_o.word_count);
          if (result_o.newly_added != want.newly_added)
            note_miss("newly_added", want.newly_added, result_o.newly_added);
          if (result_o.table_full != want.table_full)
            note_miss("table_full", want.table_full, result_o.table_full);
        end
      end
      if (start && !busy) begin
        want = count_word(word_i);
        if (pin_en) want = pin_res;
        tally_q.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("word_count_search_tree verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    word_bits_t w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 0;
    foreach (probes[p]) begin
      for (int unsigned r = 0; r < probes[p].reps; r++) begin
        send_word(probes[p].key, probes[p].pinned && (r == probes[p].reps - 1),
                  probes[p].want);
      end
      seen_words.push_back(probes[p].key);
    end

    for (int p = 0; p < PHASES; p++) begin
      idle_pct = phase_idle[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 45) begin
          w = seen_words[$urandom_range(seen_words.size() - 1)];
        end else begin
          w = fresh_word();
          seen_words.push_back(w);
          last_fresh = w;
        end
        send_word(w, 1'b0, RES_NONE);
      end
    end
    start <= 1'b0;

    while (tally_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && tally_q.size() == 0) begin
      $display("word_count_search_tree verification clean");
    end else begin
      $display("word_count_search_tree verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/wcst_pkg.sv
hdl/wcst_ram.sv
hdl/wcst_walk.sv
hdl/word_count_search_tree.sv
tb/tb_top.sv
